@@ hw/rtl/rfdm_pkg.sv @@
// Shared types, direction codes and the dominant-direction table for the
// raster flow direction mask block. No dependencies.
package rfdm_pkg;

    localparam int ELEV_BITS = 16;
    localparam int DIM_BITS  = 16;
    localparam int NUM_POS   = 9;
    localparam int CTR_POS   = 4;

    localparam int APB_DATA_BITS = 32;
    localparam int APB_ADDR_BITS = 3;

    localparam logic REG_ROWS = 1'b0;
    localparam logic REG_COLS = 1'b1;

    localparam logic [7:0] DIR_E  = 8'd1;
    localparam logic [7:0] DIR_SE = 8'd2;
    localparam logic [7:0] DIR_S  = 8'd4;
    localparam logic [7:0] DIR_SW = 8'd8;
    localparam logic [7:0] DIR_W  = 8'd16;
    localparam logic [7:0] DIR_NW = 8'd32;
    localparam logic [7:0] DIR_N  = 8'd64;
    localparam logic [7:0] DIR_NE = 8'd128;

    localparam logic [7:0] EDGE_TOP    = DIR_NW | DIR_N | DIR_NE;
    localparam logic [7:0] EDGE_BOTTOM = DIR_SE | DIR_S | DIR_SW;
    localparam logic [7:0] EDGE_LEFT   = DIR_SW | DIR_W | DIR_NW;
    localparam logic [7:0] EDGE_RIGHT  = DIR_NE | DIR_E | DIR_SE;

    // Direction code of each window position, centre has none.
    localparam logic [7:0] POS_CODE [NUM_POS] = '{
        DIR_NW, DIR_N, DIR_NE, DIR_W, 8'd0, DIR_E, DIR_SW, DIR_S, DIR_SE
    };

    typedef struct packed {
        logic [NUM_POS-1:0][ELEV_BITS-1:0] elev;
        logic [NUM_POS-1:0]                miss;
        logic [DIM_BITS-1:0]               row;
        logic [DIM_BITS-1:0]               col;
    } t_item;

    typedef struct packed {
        logic [7:0] flow_mask;
        logic       undefined_flag;
        logic [7:0] dominant_dir;
    } t_result;

    typedef struct packed {
        logic [DIM_BITS-1:0] last_row;
        logic [DIM_BITS-1:0] last_col;
    } t_bounds;

    function automatic logic [7:0] dominant(input logic [7:0] m);
        logic [7:0] d;
        d = m;
        case (m)
            DIR_E | DIR_SE,
            DIR_NE | DIR_E:                            d = DIR_E;
            DIR_SE | DIR_S,
            DIR_S | DIR_SW:                            d = DIR_S;
            DIR_SW | DIR_W,
            DIR_W | DIR_NW:                            d = DIR_W;
            DIR_NW | DIR_N,
            DIR_N | DIR_NE:                            d = DIR_N;
            DIR_E | DIR_SE | DIR_S:                    d = DIR_SE;
            DIR_SE | DIR_S | DIR_SW:                   d = DIR_S;
            DIR_S | DIR_SW | DIR_W:                    d = DIR_SW;
            DIR_SW | DIR_W | DIR_NW:                   d = DIR_W;
            DIR_W | DIR_NW | DIR_N:                    d = DIR_NW;
            DIR_NW | DIR_N | DIR_NE:                   d = DIR_N;
            DIR_N | DIR_NE | DIR_E:                    d = DIR_NE;
            DIR_NE | DIR_E | DIR_SE:                   d = DIR_E;
            DIR_NE | DIR_E | DIR_SE | DIR_S,
            DIR_N | DIR_NE | DIR_E | DIR_SE:           d = DIR_E;
            DIR_E | DIR_SE | DIR_S | DIR_SW,
            DIR_SE | DIR_S | DIR_SW | DIR_W:           d = DIR_S;
            DIR_SW | DIR_W | DIR_NW | DIR_N,
            DIR_S | DIR_SW | DIR_W | DIR_NW:           d = DIR_W;
            DIR_NW | DIR_N | DIR_NE | DIR_E,
            DIR_W | DIR_NW | DIR_N | DIR_NE:           d = DIR_N;
            DIR_N | DIR_NE | DIR_E | DIR_SE | DIR_S:   d = DIR_E;
            DIR_NE | DIR_E | DIR_SE | DIR_S | DIR_SW:  d = DIR_SE;
            DIR_E | DIR_SE | DIR_S | DIR_SW | DIR_W:   d = DIR_S;
            DIR_SE | DIR_S | DIR_SW | DIR_W | DIR_NW:  d = DIR_SW;
            DIR_S | DIR_SW | DIR_W | DIR_NW | DIR_N:   d = DIR_W;
            DIR_SW | DIR_W | DIR_NW | DIR_N | DIR_NE:  d = DIR_NW;
            DIR_W | DIR_NW | DIR_N | DIR_NE | DIR_E:   d = DIR_N;
            DIR_NW | DIR_N | DIR_NE | DIR_E | DIR_SE:  d = DIR_NE;
            default:                                   d = m;
        endcase
        return d;
    endfunction

endpackage

@@ hw/rtl/rfdm_core.sv @@
// Flow mask logic for one registered window: neighbour compares, edge rules
// and dominant-direction lookup. Depends on rfdm_pkg.
module rfdm_core (
    input  rfdm_pkg::t_item   i_item,
    input  rfdm_pkg::t_bounds i_bounds,
    output rfdm_pkg::t_result o_result
);

    logic [7:0] w_lower;
    logic [7:0] w_mask;
    logic       w_undef;
    logic       w_row0;
    logic       w_rowl;
    logic       w_col0;
    logic       w_coll;
    logic       w_nodata;

    assign w_nodata = i_item.miss[rfdm_pkg::CTR_POS];
    assign w_row0   = (i_item.row == '0);
    assign w_rowl   = (i_item.row == i_bounds.last_row);
    assign w_col0   = (i_item.col == '0);
    assign w_coll   = (i_item.col == i_bounds.last_col);

    always_comb begin
        w_lower = '0;
        for (int i = 0; i < rfdm_pkg::NUM_POS; i++) begin
            if (i != rfdm_pkg::CTR_POS && !i_item.miss[i] &&
                ($signed(i_item.elev[i]) < $signed(i_item.elev[rfdm_pkg::CTR_POS]))) begin
                w_lower = w_lower | rfdm_pkg::POS_CODE[i];
            end
        end
        if (w_nodata) begin
            w_lower = '0;
        end
    end

    // Column rules override row rules.
    always_comb begin
        w_mask  = w_lower;
        w_undef = w_nodata;
        if (w_lower == '0) begin
            if (w_row0) begin
                w_mask  = rfdm_pkg::EDGE_TOP;
                w_undef = 1'b0;
            end
            if (w_rowl) begin
                w_mask  = rfdm_pkg::EDGE_BOTTOM;
                w_undef = 1'b0;
            end
            if (w_col0) begin
                if (w_row0) begin
                    w_mask = rfdm_pkg::DIR_NW;
                end else if (w_rowl) begin
                    w_mask = rfdm_pkg::DIR_SW;
                end else begin
                    w_mask = rfdm_pkg::EDGE_LEFT;
                end
                w_undef = 1'b0;
            end
            if (w_coll) begin
                if (w_row0) begin
                    w_mask = rfdm_pkg::DIR_NE;
                end else if (w_rowl) begin
                    w_mask = rfdm_pkg::DIR_SE;
                end else begin
                    w_mask = rfdm_pkg::EDGE_RIGHT;
                end
                w_undef = 1'b0;
            end
        end
    end

    always_comb begin
        if (w_undef) begin
            o_result.flow_mask      = '0;
            o_result.undefined_flag = 1'b1;
            o_result.dominant_dir   = '0;
        end else begin
            o_result.flow_mask      = w_mask;
            o_result.undefined_flag = 1'b0;
            o_result.dominant_dir   = rfdm_pkg::dominant(w_mask);
        end
    end

endmodule

@@ hw/rtl/raster_flow_direction_mask.sv @@
// Top level of the raster flow direction mask block: input register, result
// register, handshakes and APB register file. Depends on rfdm_pkg, rfdm_core.
//
//   channel  | handshake              | beat
//   ---------+------------------------+--------------------------------------
//   input    | i_in_valid / o_in_ready | 3x3 window, missing mask, row, column
//   output   | o_out_valid / i_out_ready | flow mask, undefined flag, dominant
//   config   | APB psel/penable/pwrite | rows_in_use @0x0, cols_in_use @0x4
//
// One beat per cycle sustained while the output is not stalled; each beat passes the
// input register, then compare and edge logic into the result register.
// Synchronous active-low reset empties both stages and sets both sizes to 1.
// A stalled output holds its beat; the input stage keeps accepting while it is empty
// or the result register is free or being drained in the same cycle.
module raster_flow_direction_mask (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic signed [rfdm_pkg::ELEV_BITS-1:0] i_elev_nw,
    input  logic signed [rfdm_pkg::ELEV_BITS-1:0] i_elev_n,
    input  logic signed [rfdm_pkg::ELEV_BITS-1:0] i_elev_ne,
    input  logic signed [rfdm_pkg::ELEV_BITS-1:0] i_elev_w,
    input  logic signed [rfdm_pkg::ELEV_BITS-1:0] i_elev_center,
    input  logic signed [rfdm_pkg::ELEV_BITS-1:0] i_elev_e,
    input  logic signed [rfdm_pkg::ELEV_BITS-1:0] i_elev_sw,
    input  logic signed [rfdm_pkg::ELEV_BITS-1:0] i_elev_s,
    input  logic signed [rfdm_pkg::ELEV_BITS-1:0] i_elev_se,
    input  logic [rfdm_pkg::NUM_POS-1:0]          i_missing_mask,
    input  logic [rfdm_pkg::DIM_BITS-1:0]         i_cell_row,
    input  logic [rfdm_pkg::DIM_BITS-1:0]         i_cell_col,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic [7:0]                           o_flow_mask,
    output logic                                 o_undefined_flag,
    output logic [7:0]                           o_dominant_dir,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [rfdm_pkg::APB_ADDR_BITS-1:0]    paddr,
    input  logic [rfdm_pkg::APB_DATA_BITS-1:0]    pwdata,
    output logic [rfdm_pkg::APB_DATA_BITS-1:0]    prdata,
    output logic                                 pready
);

    rfdm_pkg::t_item     n_item;
    rfdm_pkg::t_item     r_item;
    rfdm_pkg::t_result   w_res;
    rfdm_pkg::t_result   r_res;
    rfdm_pkg::t_bounds   r_bounds;
    logic [rfdm_pkg::DIM_BITS-1:0] r_rows;
    logic [rfdm_pkg::DIM_BITS-1:0] r_cols;
    logic [rfdm_pkg::DIM_BITS-1:0] w_wdata;
    logic r_s1_valid;
    logic r_out_valid;
    logic w_s1_ready;
    logic w_out_free;
    logic w_cfg_wr;

    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_s1_ready = !r_s1_valid || w_out_free;
    assign o_in_ready = w_s1_ready;
    assign pready     = 1'b1;
    assign w_cfg_wr   = psel && penable && pwrite && pready;
    assign w_wdata    = pwdata[rfdm_pkg::DIM_BITS-1:0];

    always_comb begin
        n_item.elev[0] = i_elev_nw;
        n_item.elev[1] = i_elev_n;
        n_item.elev[2] = i_elev_ne;
        n_item.elev[3] = i_elev_w;
        n_item.elev[4] = i_elev_center;
        n_item.elev[5] = i_elev_e;
        n_item.elev[6] = i_elev_sw;
        n_item.elev[7] = i_elev_s;
        n_item.elev[8] = i_elev_se;
        n_item.miss    = i_missing_mask;
        n_item.row     = i_cell_row;
        n_item.col     = i_cell_col;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_s1_ready) begin
                r_s1_valid <= i_in_valid;
            end
            if (w_out_free) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && w_s1_ready) begin
            r_item <= n_item;
        end
        if (r_s1_valid && w_out_free) begin
            r_res <= w_res;
        end
    end

    // Keep last-index copies so the core sees plain equality compares.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows            <= rfdm_pkg::DIM_BITS'(1);
            r_cols            <= rfdm_pkg::DIM_BITS'(1);
            r_bounds.last_row <= '0;
            r_bounds.last_col <= '0;
        end else if (w_cfg_wr) begin
            case (paddr[2])
                rfdm_pkg::REG_ROWS: begin
                    r_rows            <= w_wdata;
                    r_bounds.last_row <= w_wdata - rfdm_pkg::DIM_BITS'(1);
                end
                rfdm_pkg::REG_COLS: begin
                    r_cols            <= w_wdata;
                    r_bounds.last_col <= w_wdata - rfdm_pkg::DIM_BITS'(1);
                end
                default: begin
                    r_rows <= r_rows;
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            rfdm_pkg::REG_ROWS: prdata = rfdm_pkg::APB_DATA_BITS'(r_rows);
            rfdm_pkg::REG_COLS: prdata = rfdm_pkg::APB_DATA_BITS'(r_cols);
            default:            prdata = '0;
        endcase
    end

    rfdm_core u_core (
        .i_item   (r_item),
        .i_bounds (r_bounds),
        .o_result (w_res)
    );

    assign o_out_valid      = r_out_valid;
    assign o_flow_mask      = r_res.flow_mask;
    assign o_undefined_flag = r_res.undefined_flag;
    assign o_dominant_dir   = r_res.dominant_dir;

    a_undef_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_undefined_flag |-> o_flow_mask == '0 && o_dominant_dir == '0)
        else $error("undefined result with nonzero mask");

    a_dom_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_flow_mask != '0 |-> o_dominant_dir != '0)
        else $error("dominant direction lost for nonzero mask");

    a_s1_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> r_s1_valid)
        else $error("accepted beat not held in input stage");

    a_s1_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && w_out_free |=> r_out_valid)
        else $error("input stage beat not moved to result register");

endmodule
